FILE: hdl/ahsch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahsch_pkg: shared types and constants
// Widths, codes and the controller/datapath command and status structs of the
// recursive-halving all-gather step scheduler.
// ----------------------------------------------------------------------------
package ahsch_pkg;

    localparam int MAX_RANKS = 64;
    localparam int MAX_OUT   = 32;
    localparam int IDX_W     = $clog2(MAX_RANKS);       // slice / peer index
    localparam int RANK_W    = $clog2(MAX_RANKS + 1);   // rank count
    localparam int CNT_W     = $clog2(MAX_OUT + 1);     // result count
    localparam int STEP_W    = 6;
    localparam int STT_W     = 3;
    localparam int RPT_W     = 16;
    localparam int SB_W      = 32;
    localparam int OFF_W     = 48;
    localparam int CIDX_W    = 3;
    localparam int CDAT_W    = 48;
    localparam int MSTEP_W   = $clog2(RANK_W);           // modulo step counter

    typedef enum logic [CIDX_W-1:0] {
        CFG_RANK_COUNT     = 3'd0,
        CFG_OWN_POSITION   = 3'd1,
        CFG_STEP_TOTAL     = 3'd2,
        CFG_SLICE_BYTES    = 3'd3,
        CFG_SCRATCH_ORIGIN = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MOD_POS  = 1'b0,
        MOD_DIST = 1'b1
    } t_mod_sel;

    typedef struct packed {
        logic [STEP_W-1:0] step_number;
        logic [RPT_W-1:0]  repeat_index;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] send_peer;
        logic [IDX_W-1:0] recv_peer;
        logic [IDX_W-1:0] tx_slice;
        logic [IDX_W-1:0] rx_slice;
        logic [OFF_W-1:0] tx_offset;
        logic [OFF_W-1:0] rx_offset;
        logic             last;
        logic             bad_step;
    } t_res;

    typedef struct packed {
        logic [CIDX_W-1:0] index;
        logic [CDAT_W-1:0] value;
    } t_cfg;

    typedef struct packed {
        logic     load;
        logic     mod_start;
        t_mod_sel mod_sel;
        logic     pos_save;
        logic     dist_save;
        logic     prep;
        logic     base;
        logic     orig;
        logic     mul;
        logic     emit;
        logic     emit_bad;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic mod_done;
        logic slot_free;
        logic none_left;
        logic last;
    } t_sts;

endpackage
`default_nettype wire

FILE: hdl/ahsch_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahsch_if: valid/ready channels
// Request, result and register-write channels of the step scheduler.
// ----------------------------------------------------------------------------
interface ahsch_req_if;
    import ahsch_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ahsch_res_if;
    import ahsch_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ahsch_cfg_if;
    import ahsch_pkg::*;
    logic valid;
    logic ready;
    t_cfg data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ahsch_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahsch_mod: small restoring modulo unit
// Remainder of a RANK_W-bit value by the rank count, one bit per cycle.
// ----------------------------------------------------------------------------
module ahsch_mod
    import ahsch_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RANK_W-1:0] i_dividend,
    input  wire logic [RANK_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [RANK_W-1:0]      o_rem
);

    logic               r_busy;
    logic               r_done;
    logic [MSTEP_W-1:0] r_cnt;
    logic [RANK_W-1:0]  r_rem;
    logic [RANK_W-1:0]  r_dvd;
    logic [RANK_W:0]    n_trial;
    logic [RANK_W-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[RANK_W-1]};
        if (n_trial >= {1'b0, i_divisor}) begin
            n_rem = RANK_W'(n_trial - {1'b0, i_divisor});
        end else begin
            n_rem = n_trial[RANK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MSTEP_W'(RANK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[RANK_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: hdl/ahsch_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahsch_dp: scheduler datapath
// Register file, peer and slice arithmetic, offset multipliers and the
// result output register.
// ----------------------------------------------------------------------------
module ahsch_dp
    import ahsch_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    input  wire t_req i_req_data,
    input  wire logic i_cfg_we,
    input  wire t_cfg i_cfg_data,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_res      o_out_data
);

    // registers
    logic [RANK_W-1:0] r_rank_count;
    logic [IDX_W-1:0]  r_own_position;
    logic [STT_W-1:0]  r_step_total;
    logic [SB_W-1:0]   r_slice_bytes;
    logic [OFF_W-1:0]  r_scratch_origin;

    // per-request state
    logic [STEP_W-1:0]    r_step;
    logic [RPT_W-1:0]     r_rpt;
    logic [IDX_W-1:0]     r_pos;
    logic [IDX_W-1:0]     r_dist_m;
    logic [IDX_W-1:0]     r_dist2_m;
    logic [IDX_W-1:0]     r_send_peer;
    logic [IDX_W-1:0]     r_recv_peer;
    logic [IDX_W-1:0]     r_tx;
    logic [IDX_W-1:0]     r_rx;
    logic [CNT_W-1:0]     r_left;
    logic [OFF_W-1:0]     r_prod;
    logic [OFF_W-1:0]     r_region;
    logic [SB_W+IDX_W-1:0] r_tx_prod;
    logic [SB_W+IDX_W-1:0] r_rx_prod;
    logic                 r_out_valid;
    t_res                 r_out;

    logic [RANK_W-1:0]  eff_r;
    logic [STT_W-1:0]   dist_exp;
    logic [RANK_W-1:0]  dist_pow;
    logic [RANK_W:0]    span;
    logic [RANK_W:0]    n_full;
    logic [CNT_W-1:0]   n_cnt;
    logic [RANK_W-1:0]  mod_dividend;
    logic [RANK_W-1:0]  mod_rem;
    logic               mod_done;
    logic [RANK_W:0]    dist2_raw;
    logic [RANK_W:0]    send_sum;
    logic [IDX_W-1:0]   send_peer;
    logic [IDX_W-1:0]   recv_peer;
    logic [IDX_W-1:0]   tx_next;
    logic [IDX_W-1:0]   rx_next;
    logic               slot_free;

    // rank count clamped to 1..MAX_RANKS
    always_comb begin
        if (r_rank_count == '0) begin
            eff_r = RANK_W'(1);
        end else if (r_rank_count > RANK_W'(MAX_RANKS)) begin
            eff_r = RANK_W'(MAX_RANKS);
        end else begin
            eff_r = r_rank_count;
        end
    end

    // d = 2^(steps-1-step), only meaningful when the step is in range
    assign dist_exp = STT_W'(r_step_total - STT_W'(1) - r_step[STT_W-1:0]);
    assign dist_pow = RANK_W'(1) << dist_exp;
    assign span     = (RANK_W+1)'(eff_r) - (RANK_W+1)'(1) + (RANK_W+1)'(dist_pow);
    assign n_full   = span >> (dist_exp + STT_W'(1));
    assign n_cnt    = (n_full > (RANK_W+1)'(MAX_OUT)) ? CNT_W'(MAX_OUT)
                                                      : CNT_W'(n_full);

    assign mod_dividend = (i_cmd.mod_sel == MOD_DIST) ? dist_pow
                                                      : RANK_W'(r_own_position);

    ahsch_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (eff_r),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // 2d mod r from d mod r: one compare and subtract
    always_comb begin
        dist2_raw = {1'b0, RANK_W'(r_dist_m)} << 1;
        if (dist2_raw >= (RANK_W+1)'(eff_r)) begin
            dist2_raw = dist2_raw - (RANK_W+1)'(eff_r);
        end
    end

    always_comb begin
        send_sum = (RANK_W+1)'(r_pos) + (RANK_W+1)'(r_dist_m);
        if (send_sum >= (RANK_W+1)'(eff_r)) begin
            send_sum = send_sum - (RANK_W+1)'(eff_r);
        end
        send_peer = IDX_W'(send_sum);
        if (r_pos >= r_dist_m) begin
            recv_peer = r_pos - r_dist_m;
        end else begin
            recv_peer = IDX_W'(RANK_W'(r_pos) + eff_r - RANK_W'(r_dist_m));
        end
    end

    // slice indices step down by 2d, wrapping in the ring
    always_comb begin
        if (r_tx >= r_dist2_m) begin
            tx_next = r_tx - r_dist2_m;
        end else begin
            tx_next = IDX_W'(RANK_W'(r_tx) + eff_r - RANK_W'(r_dist2_m));
        end
        if (r_rx >= r_dist2_m) begin
            rx_next = r_rx - r_dist2_m;
        end else begin
            rx_next = IDX_W'(RANK_W'(r_rx) + eff_r - RANK_W'(r_dist2_m));
        end
    end

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank_count     <= RANK_W'(1);
            r_own_position   <= '0;
            r_step_total     <= STT_W'(1);
            r_slice_bytes    <= '0;
            r_scratch_origin <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_data.index)
                CFG_RANK_COUNT:     r_rank_count     <= i_cfg_data.value[RANK_W-1:0];
                CFG_OWN_POSITION:   r_own_position   <= i_cfg_data.value[IDX_W-1:0];
                CFG_STEP_TOTAL:     r_step_total     <= i_cfg_data.value[STT_W-1:0];
                CFG_SLICE_BYTES:    r_slice_bytes    <= i_cfg_data.value[SB_W-1:0];
                CFG_SCRATCH_ORIGIN: r_scratch_origin <= i_cfg_data.value[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_tx        <= '0;
            r_rx        <= '0;
            r_region    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit || i_cmd.emit_bad) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.prep) begin
                r_left <= n_cnt;
                r_tx   <= r_pos;
                r_rx   <= recv_peer;
            end
            if (i_cmd.orig) begin
                r_region <= r_scratch_origin + r_prod;
            end
            if (i_cmd.emit) begin
                r_left <= r_left - 1'b1;
                r_tx   <= tx_next;
                r_rx   <= rx_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_step <= i_req_data.step_number;
            r_rpt  <= i_req_data.repeat_index;
        end
        if (i_cmd.pos_save) begin
            r_pos <= IDX_W'(mod_rem);
        end
        if (i_cmd.dist_save) begin
            r_dist_m <= IDX_W'(mod_rem);
        end
        if (i_cmd.prep) begin
            r_dist2_m   <= IDX_W'(dist2_raw);
            r_send_peer <= send_peer;
            r_recv_peer <= recv_peer;
            r_prod      <= OFF_W'(r_rpt * r_slice_bytes);
        end
        if (i_cmd.base) begin
            r_prod <= OFF_W'(r_prod * eff_r);
        end
        if (i_cmd.mul) begin
            r_tx_prod <= r_slice_bytes * r_tx;
            r_rx_prod <= r_slice_bytes * r_rx;
        end
        if (i_cmd.emit) begin
            r_out.send_peer <= r_send_peer;
            r_out.recv_peer <= r_recv_peer;
            r_out.tx_slice  <= r_tx;
            r_out.rx_slice  <= r_rx;
            r_out.tx_offset <= r_region + OFF_W'(r_tx_prod);
            r_out.rx_offset <= r_region + OFF_W'(r_rx_prod);
            r_out.last      <= (r_left == CNT_W'(1));
            r_out.bad_step  <= 1'b0;
        end else if (i_cmd.emit_bad) begin
            r_out <= '{last: 1'b1, bad_step: 1'b1, default: '0};
        end
    end

    assign o_sts.bad       = (r_step >= STEP_W'(r_step_total));
    assign o_sts.mod_done  = mod_done;
    assign o_sts.slot_free = slot_free;
    assign o_sts.none_left = (r_left == '0);
    assign o_sts.last      = (r_left == CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: hdl/ahsch_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahsch_ctrl: scheduler sequencer
// One-hot state machine that walks a request through setup and emission.
// ----------------------------------------------------------------------------
module ahsch_ctrl
    import ahsch_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_MODP   = 10'b00_0000_0100,
        S_MODD   = 10'b00_0000_1000,
        S_PREP   = 10'b00_0001_0000,
        S_BASE   = 10'b00_0010_0000,
        S_ORIG   = 10'b00_0100_0000,
        S_MUL    = 10'b00_1000_0000,
        S_EMIT   = 10'b01_0000_0000,
        S_BADW   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.bad) begin
                    n_state = S_BADW;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_sel   = MOD_POS;
                    n_state         = S_MODP;
                end
            end
            S_MODP: begin
                if (i_sts.mod_done) begin
                    o_cmd.pos_save  = 1'b1;
                    o_cmd.mod_start = 1'b1;
                    o_cmd.mod_sel   = MOD_DIST;
                    n_state         = S_MODD;
                end
            end
            S_MODD: begin
                o_cmd.mod_sel = MOD_DIST;
                if (i_sts.mod_done) begin
                    o_cmd.dist_save = 1'b1;
                    n_state         = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_BASE;
            end
            S_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = S_ORIG;
            end
            S_ORIG: begin
                o_cmd.orig = 1'b1;
                n_state    = i_sts.none_left ? S_IDLE : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last ? S_IDLE : S_MUL;
                end
            end
            S_BADW: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit_bad = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

FILE: hdl/allgather_halving_step_schedule.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// allgather_halving_step_schedule: recursive-halving all-gather step schedule
// For one rank and one step, works out the send/receive peers and emits one
// result per slice moved, with slice indices and scratch byte offsets.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake            | carries
//  ---------+-----+----------------------+----------------------------------
//  i_req    | in  | valid / ready        | step_number, repeat_index
//  o_res    | out | valid / ready        | peers, slices, offsets, last, bad
//  i_cfg    | in  | valid / ready (=1)   | register index, write data
//
//  One request at a time. Setup runs mostly in the bit-serial modulo
//  unit, run twice (own position mod r, then distance mod r). Each result
//  then goes through the slice-size multiplies and then the load of the
//  output register. A bad step skips setup and emits one flagged result.
//  A stalled result holds in the output register and holds the sequencer.
//  Synchronous active-low reset; registers come back to their reset values.
// ----------------------------------------------------------------------------
module allgather_halving_step_schedule
    import ahsch_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ahsch_req_if.sink    i_req,
    ahsch_res_if.source  o_res,
    ahsch_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;
    logic cfg_we;

    // register writes are always taken; the host must write only while idle, which the block does not enforce
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    ahsch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ahsch_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_data  (i_req.data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_data  (o_res.data)
    );

endmodule
`default_nettype wire

FILE: hdl/ahsch_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ahsch_chk: port-level checks
// Watches the request and result channels of the step scheduler.
// ----------------------------------------------------------------------------
module ahsch_chk
    import ahsch_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_res_valid,
    input wire logic i_res_ready,
    input wire t_res i_res_data
);

    // a held result stays up
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // one request at a time
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // a bad step is marked as the final result
    a_bad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.bad_step |-> i_res_data.last)
        else $error("bad step not marked last");

    // a bad step carries no schedule
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.bad_step |->
            i_res_data.send_peer == '0 && i_res_data.recv_peer == '0 &&
            i_res_data.tx_slice == '0 && i_res_data.rx_slice == '0 &&
            i_res_data.tx_offset == '0 && i_res_data.rx_offset == '0)
        else $error("bad step carries nonzero fields");

endmodule

bind allgather_halving_step_schedule ahsch_chk u_ahsch_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);
`default_nettype wire

FILE: tb/allgather_halving_step_schedule_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allgather_halving_step_schedule_test: self-checking bench for the step scheduler
// Sends step requests and register writes over the valid/ready channels. A
// scoreboard works out the peers, slice indices and scratch offsets of every
// request and compares each result with them, field by field.
// ----------------------------------------------------------------------------
module allgather_halving_step_schedule_test;
    import ahsch_pkg::*;

    localparam int QUIET_LIMIT = 4000;  // cycles without any handshake
    localparam int SETTLE      = 48;    // covers request setup plus a few results
    localparam int MAX_GAP     = 12;    // longest idle/stall per item
    localparam int RANDOM_REQS = 250;
    localparam int PHASE_REQS  = 25;    // requests between register updates

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   idle_on = 1'b0;               // both sides insert gaps while set

    ahsch_req_if req_ch ();
    ahsch_res_if res_ch ();
    ahsch_cfg_if cfg_ch ();

    allgather_halving_step_schedule dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow copy of the registers, schedule prediction, checking
    // ------------------------------------------------------------------------
    class step_schedule_board;
        localparam int MAX_SHOWN = 50;  // keep the log short on a bad run

        logic [RANK_W-1:0] rank_reg;
        logic [IDX_W-1:0]  position_reg;
        logic [STT_W-1:0]  steps_reg;
        logic [SB_W-1:0]   slice_size_reg;
        logic [OFF_W-1:0]  origin_reg;
        t_res              slices_due[$];
        int                mismatches;

        function new();
            rank_reg       = RANK_W'(1);
            position_reg   = '0;
            steps_reg      = STT_W'(1);
            slice_size_reg = '0;
            origin_reg     = '0;
            mismatches     = 0;
        endfunction

        function void load_register(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] value);
            case (idx)
                CFG_RANK_COUNT:     rank_reg       = value[RANK_W-1:0];
                CFG_OWN_POSITION:   position_reg   = value[IDX_W-1:0];
                CFG_STEP_TOTAL:     steps_reg      = value[STT_W-1:0];
                CFG_SLICE_BYTES:    slice_size_reg = value[SB_W-1:0];
                CFG_SCRATCH_ORIGIN: origin_reg     = value[OFF_W-1:0];
                default: ;
            endcase
        endfunction

        // Expected results of one accepted step request.
        function void plan_step(t_req req);
            t_res        res;
            int          ring, me, stride, hop, count, tx, rx, send_to, recv_from, k;
            logic [63:0] region;
            res = '0;
            // Step out of range: a single flagged result, nothing else.
            if (req.step_number >= steps_reg) begin
                res.last     = 1'b1;
                res.bad_step = 1'b1;
                slices_due = {slices_due, res};
                return;
            end
            ring = (rank_reg == 0) ? 1 : (rank_reg > MAX_RANKS) ? MAX_RANKS : int'(rank_reg);
            me   = position_reg % ring;
            stride = 1 << (int'(steps_reg) - 1 - int'(req.step_number));
            hop  = (2 * stride) % ring;
            count = (ring - 1 + stride) / (2 * stride);
            if (count > MAX_OUT)
                count = MAX_OUT;
            send_to   = (me + stride % ring) % ring;
            recv_from = (me + ring - stride % ring) % ring;
            region = 64'(origin_reg)
                   + 64'(req.repeat_index) * 64'(slice_size_reg) * 64'(ring);
            tx = me;
            rx = recv_from;
            for (k = 0; k < count; k++) begin
                res.send_peer = IDX_W'(send_to);
                res.recv_peer = IDX_W'(recv_from);
                res.tx_slice  = IDX_W'(tx);
                res.rx_slice  = IDX_W'(rx);
                res.tx_offset = OFF_W'(region + 64'(slice_size_reg) * 64'(tx));
                res.rx_offset = OFF_W'(region + 64'(slice_size_reg) * 64'(rx));
                res.last      = (k + 1 == count);
                res.bad_step  = 1'b0;
                slices_due = {slices_due, res};
                tx = (tx + ring - hop) % ring;
                rx = (rx + ring - hop) % ring;
            end
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%0t ns: %s", $time, what);
        endtask

        task compare(string field, logic [OFF_W-1:0] got, logic [OFF_W-1:0] want);
            if (got !== want)
                report($sformatf("%s: got %0h, expected %0h", field, got, want));
        endtask

        task check_result(t_res got);
            t_res want;
            if (slices_due.size() == 0) begin
                report($sformatf("result %0h arrived with none expected", got));
                return;
            end
            want = slices_due.pop_front();
            compare("send_peer", got.send_peer, want.send_peer);
            compare("recv_peer", got.recv_peer, want.recv_peer);
            compare("tx_slice",  got.tx_slice,  want.tx_slice);
            compare("rx_slice",  got.rx_slice,  want.rx_slice);
            compare("tx_offset", got.tx_offset, want.tx_offset);
            compare("rx_offset", got.rx_offset, want.rx_offset);
            compare("last",      got.last,      want.last);
            compare("bad_step",  got.bad_step,  want.bad_step);
        endtask
    endclass

    step_schedule_board board;

    // ------------------------------------------------------------------------
    // Drivers. All inputs move at the falling edge; handshakes are seen at
    // the rising edge. Every driver task starts and returns on a falling edge.
    // ------------------------------------------------------------------------

    // One register write; valid is left high so writes can go back to back.
    task automatic write_register(input logic [CIDX_W-1:0] idx,
                                  input logic [CDAT_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.load_register(idx, value);
        @(negedge i_clk);
    endtask

    // Field value in the low bits; half the time the unused high bits carry junk
    // so that the register masking is exercised.
    function automatic logic [CDAT_W-1:0] pad(logic [CDAT_W-1:0] field, int width);
        logic [CDAT_W-1:0] keep;
        keep = (CDAT_W'(1) << width) - 1'b1;
        if ($urandom_range(0, 1) == 0)
            return field & keep;
        return (field & keep) | (CDAT_W'({$urandom, $urandom}) & ~keep);
    endfunction

    // Drop the request valid, wait for every expected result, then let a
    // request that produces no results finish inside the block.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (board.slices_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Register update, only with the block idle. Sometimes an unmapped index
    // is written too; it must be ignored.
    task automatic program_registers(input logic [RANK_W-1:0] ranks,
                                     input logic [IDX_W-1:0]  pos,
                                     input logic [STT_W-1:0]  steps,
                                     input logic [SB_W-1:0]   slice,
                                     input logic [OFF_W-1:0]  origin);
        settle();
        write_register(CFG_RANK_COUNT,     pad(CDAT_W'(ranks), RANK_W));
        write_register(CFG_OWN_POSITION,   pad(CDAT_W'(pos), IDX_W));
        if ($urandom_range(0, 3) == 0)
            write_register(CIDX_W'(CFG_SCRATCH_ORIGIN) + CIDX_W'($urandom_range(1, 3)),
                           CDAT_W'({$urandom, $urandom}));
        write_register(CFG_STEP_TOTAL,     pad(CDAT_W'(steps), STT_W));
        write_register(CFG_SLICE_BYTES,    pad(CDAT_W'(slice), SB_W));
        write_register(CFG_SCRATCH_ORIGIN, CDAT_W'(origin));
        cfg_ch.valid <= 1'b0;
    endtask

    // Random register set. Small rings dominate so the run stays short; full
    // size, zero and oversized rank counts show up in a few phases.
    task automatic random_registers();
        logic [RANK_W-1:0] ranks;
        logic [STT_W-1:0]  steps;
        logic [SB_W-1:0]   slice;
        int                span;
        case ($urandom_range(0, 7))
            0:       ranks = RANK_W'($urandom_range(0, 2**RANK_W - 1));
            1:       ranks = RANK_W'(MAX_RANKS);
            2:       ranks = RANK_W'($urandom_range(1, 4));
            default: ranks = RANK_W'($urandom_range(1, 16));
        endcase
        span  = (ranks == 0) ? 1 : (ranks > MAX_RANKS) ? MAX_RANKS : int'(ranks);
        steps = (span == 1) ? STT_W'(1) : STT_W'($clog2(span));
        if ($urandom_range(0, 4) == 0)
            steps = STT_W'($urandom_range(0, 2**STT_W - 1));
        slice = ($urandom_range(0, 1) != 0) ? SB_W'($urandom) : SB_W'($urandom_range(0, 255));
        program_registers(ranks, IDX_W'($urandom_range(0, 2**IDX_W - 1)), steps, slice,
                          OFF_W'({$urandom, $urandom}));
    endtask

    // One step request. With no gap, valid stays high from the previous
    // request, so it gets a single assignment in this time step.
    task automatic push_request(input logic [STEP_W-1:0] step, input logic [RPT_W-1:0] rpt);
        int   gap;
        t_req req;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        req.step_number  = step;
        req.repeat_index = rpt;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= req;
        do @(posedge i_clk); while (!req_ch.ready);
        board.plan_step(req);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall before each result, then check it.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            board.check_result(res_ch.data);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long stretch without any handshake means the block hung.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("allgather_halving_step_schedule_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                k;
        logic [STEP_W-1:0] step;
        board        = new();
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_on = 1'b1;

        // Reset settings: one rank, so a valid step moves nothing; step 63 is bad.
        push_request('0, '0);
        push_request(STEP_W'(63), RPT_W'(16'hFFFF));

        // Full ring, last position, all-ones slice size and origin: offsets wrap.
        program_registers(RANK_W'(MAX_RANKS), IDX_W'(63), STT_W'(6), SB_W'(32'hFFFF_FFFF),
                          OFF_W'(48'hFFFF_FFFF_FFFF));
        for (k = 0; k < 6; k++)
            push_request(STEP_W'(k), (k % 2 == 0) ? RPT_W'(16'hFFFF) : RPT_W'(0));
        push_request(STEP_W'(6), RPT_W'(1));        // step equal to the step count
        push_request(STEP_W'(63), RPT_W'(2));

        // No steps at all: every step is bad. Rank count zero acts as one rank.
        program_registers('0, IDX_W'(37), '0, SB_W'(7), OFF_W'(48'h123));
        push_request('0, RPT_W'(5));
        program_registers('0, IDX_W'(37), STT_W'(3), SB_W'(7), OFF_W'(48'h123));
        push_request(STEP_W'(2), RPT_W'(5));

        // Rank count above the maximum saturates; seven steps give distances
        // of a full ring (no results) down to one (the most results).
        program_registers(RANK_W'(100), IDX_W'(40), STT_W'(7), SB_W'(32'h1000),
                          OFF_W'(48'h0FFF_0000_0000));
        push_request('0, RPT_W'(3));
        push_request(STEP_W'(1), RPT_W'(3));
        push_request(STEP_W'(6), RPT_W'(16'h8000));

        // Position beyond the ring wraps; odd ring size.
        program_registers(RANK_W'(5), IDX_W'(63), STT_W'(3), SB_W'(32'hDEAD_BEEF),
                          OFF_W'({$urandom, $urandom}));
        for (k = 0; k < 3; k++)
            push_request(STEP_W'(k), RPT_W'($urandom));

        // Two ranks: a single exchange.
        program_registers(RANK_W'(2), IDX_W'(1), STT_W'(1), SB_W'(32'h40), OFF_W'(48'h100));
        push_request('0, RPT_W'(9));

        // Random phases: mostly steps inside the step count, some out of range.
        for (k = 0; k < RANDOM_REQS; k++) begin
            if (k % PHASE_REQS == 0) begin
                random_registers();
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 4) != 0 && board.steps_reg != 0)
                step = STEP_W'($urandom_range(0, board.steps_reg - 1));
            else
                step = STEP_W'($urandom_range(0, 2**STEP_W - 1));
            push_request(step, RPT_W'($urandom));
        end

        // Drain and give a stray extra result time to show up.
        settle();
        if (board.mismatches == 0 && board.slices_due.size() == 0)
            $display("allgather_halving_step_schedule_test OK");
        else
            $display("allgather_halving_step_schedule_test NOT OK");
        $finish;
    end

endmodule
